[sv/slm_pkg.sv]
// Shared types and constants for the synthetic loss measurement session.
// Holds the transfer structs, phase and sequencer enums and register indexes.
// No dependencies.
`default_nettype none

package slm_pkg;

  // Width of every frame counter and peer sequence register.
  localparam int COUNT_WIDTH = 32;
  // Quotient bits of a loss percentage in hundredths (at most 10000).
  localparam int PCT_BITS = 14;
  localparam int PCT_SCALE = 10000;
  localparam int STEP_W = $clog2(PCT_BITS);
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 16;

  typedef enum logic [1:0] {
    ACT_START = 2'd0,
    ACT_STOP  = 2'd1,
    ACT_TICK  = 2'd2,
    ACT_REPLY = 2'd3
  } action_t;

  typedef enum logic [2:0] {
    PH_IDLE  = 3'd0,
    PH_RUN   = 3'd1,
    PH_WAIT  = 3'd2,
    PH_DONE  = 3'd3,
    PH_ABORT = 3'd4
  } phase_t;

  typedef enum logic [1:0] {
    ALARM_NONE = 2'd0,
    ALARM_FAR  = 2'd1,
    ALARM_NEAR = 2'd2
  } alarm_t;

  typedef enum logic [2:0] {
    SEQ_IDLE,
    SEQ_SPAN,
    SEQ_LOSS,
    SEQ_MUL,
    SEQ_DIV,
    SEQ_FIN
  } seq_t;

  localparam logic [CFG_IDX_W-1:0] CFG_PACKET_COUNT   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FAR_THR_EN     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_FAR_THR        = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_NEAR_THR_EN    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_NEAR_THR       = 3'd4;

  localparam logic [15:0] PACKET_COUNT_RESET = 16'd10;

  typedef struct packed {
    logic [1:0]  action;
    logic        send_ok;
    logic [31:0] reply_remote_tx;
    logic [31:0] reply_echo_tx;
  } in_item_t;

  typedef struct packed {
    logic [2:0]  session_state;
    logic [31:0] frames_sent;
    logic [31:0] frames_received;
    logic [31:0] remote_count;
    logic [31:0] far_loss;
    logic [31:0] near_loss;
    logic [13:0] far_percent;
    logic [13:0] near_percent;
    logic [1:0]  alarm_kind;
    logic        result_invalid;
    logic [31:0] last_echo_tx;
    logic [31:0] last_remote_tx;
  } out_item_t;

endpackage

`default_nettype wire

[sv/synthetic_loss_measurement_session.sv]
// Top level of the synthetic loss measurement session, initiator side.
// Depends on slm_pkg for the transfer structs, enums and constants.
`default_nettype none

// Each input transfer is one event (start, stop, timer tick or a received
// reply) and produces exactly one result transfer with the session status
// after that event. From acceptance until its result is offered, an item
// passes these steps: the accepting edge applies the event to the counters,
// then SEQ_SPAN updates the peer sequence span after a reply, SEQ_LOSS
// forms the far-end and near-end losses, SEQ_MUL scales them by 10000,
// SEQ_DIV runs two restoring dividers side by side for the 14 quotient
// bits, one quotient bit per cycle, and SEQ_FIN checks the thresholds and
// loads the output register, waiting while the previous result has not
// been taken. The divider iterations, set by the 14-bit percentage width,
// are the longest step. The block works on one item at a time, but the
// result sits in its own output register, so the next item can be accepted
// while the previous result still waits for out_ready.
// Configuration writes take effect at once and must only be issued while
// the block is idle.
module synthetic_loss_measurement_session (
  input  wire                                  clk,
  input  wire                                  rst_n,
  input  wire                                  in_valid,
  output logic                                 in_ready,
  input  slm_pkg::in_item_t                    in_data,
  output logic                                 out_valid,
  input  wire                                  out_ready,
  output slm_pkg::out_item_t                   out_data,
  input  wire                                  cfg_we,
  input  wire [slm_pkg::CFG_IDX_W-1:0]         cfg_index,
  input  wire [slm_pkg::CFG_DATA_W-1:0]        cfg_wdata
);

  localparam int CW = slm_pkg::COUNT_WIDTH;
  localparam int PB = slm_pkg::PCT_BITS;
  localparam int PW = CW + PB;

  // Configuration registers.
  logic [15:0]   pkt_count_r;
  logic          far_en_r;
  logic [PB-1:0] far_thr_r;
  logic          near_en_r;
  logic [PB-1:0] near_thr_r;

  // Session state.
  slm_pkg::phase_t phase_r, phase_nxt;
  logic [CW-1:0] sent_r, sent_nxt;
  logic [CW-1:0] recv_r, recv_nxt;
  logic [CW-1:0] min_r, min_nxt;
  logic [CW-1:0] max_r, max_nxt;
  logic [CW-1:0] span_r;
  logic [CW-1:0] echo_r, echo_nxt;
  logic [CW-1:0] peer_r, peer_nxt;
  logic          clr_span_nxt;
  logic          reply_r, reply_nxt;
  logic          ending_r, ending_nxt;
  logic          invalid_r, invalid_nxt;

  // Sequencer.
  slm_pkg::seq_t seq_r, seq_nxt;
  logic [slm_pkg::STEP_W-1:0] step_r;

  // Two divider lanes: lane 0 is the far end, lane 1 the near end.
  logic [CW-1:0] loss_r [2];
  logic [CW-1:0] den_r  [2];
  logic          dz_r   [2];
  logic [CW-1:0] rem_r  [2];
  logic [PB-1:0] dig_r  [2];
  logic [PB-1:0] quo_r  [2];
  logic [CW:0]   trial  [2];
  logic          fits   [2];
  logic [PW-1:0] prod   [2];
  logic [PB-1:0] pct    [2];
  logic          hit    [2];

  slm_pkg::out_item_t out_r;
  logic               out_valid_r;
  logic               load_out;
  logic               accept;
  logic [CW-1:0]      rtx;
  slm_pkg::alarm_t    alarm;

  assign accept   = in_valid && in_ready;
  assign in_ready = (seq_r == slm_pkg::SEQ_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_r;
  assign rtx = CW'(in_data.reply_remote_tx);

  // Configuration port.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pkt_count_r <= slm_pkg::PACKET_COUNT_RESET;
      far_en_r    <= 1'b0;
      far_thr_r   <= '0;
      near_en_r   <= 1'b0;
      near_thr_r  <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        slm_pkg::CFG_PACKET_COUNT: pkt_count_r <= cfg_wdata;
        slm_pkg::CFG_FAR_THR_EN:   far_en_r    <= cfg_wdata[0];
        slm_pkg::CFG_FAR_THR:      far_thr_r   <= cfg_wdata[PB-1:0];
        slm_pkg::CFG_NEAR_THR_EN:  near_en_r   <= cfg_wdata[0];
        slm_pkg::CFG_NEAR_THR:     near_thr_r  <= cfg_wdata[PB-1:0];
        default: ;
      endcase
    end
  end

  // Effect of one event on the session counters.
  always_comb begin
    phase_nxt    = phase_r;
    sent_nxt     = sent_r;
    recv_nxt     = recv_r;
    min_nxt      = min_r;
    max_nxt      = max_r;
    echo_nxt     = echo_r;
    peer_nxt     = peer_r;
    clr_span_nxt = 1'b0;
    reply_nxt    = 1'b0;
    ending_nxt   = 1'b0;
    invalid_nxt  = 1'b0;
    unique case (slm_pkg::action_t'(in_data.action))
      slm_pkg::ACT_START: begin
        phase_nxt    = slm_pkg::PH_RUN;
        sent_nxt     = '0;
        recv_nxt     = '0;
        min_nxt      = '1;
        max_nxt      = '0;
        echo_nxt     = '0;
        peer_nxt     = '0;
        clr_span_nxt = 1'b1;
      end
      slm_pkg::ACT_STOP: begin
        invalid_nxt = (phase_r != slm_pkg::PH_DONE);
        phase_nxt   = slm_pkg::PH_ABORT;
      end
      slm_pkg::ACT_TICK: begin
        if (phase_r == slm_pkg::PH_RUN) begin
          if (in_data.send_ok) begin
            sent_nxt = sent_r + CW'(1);
          end
          // A zero packet count matches only while no frame has gone out.
          if (sent_nxt == CW'(pkt_count_r)) begin
            phase_nxt = slm_pkg::PH_WAIT;
          end
        end else if (phase_r == slm_pkg::PH_WAIT) begin
          phase_nxt  = slm_pkg::PH_DONE;
          ending_nxt = 1'b1;
        end
      end
      slm_pkg::ACT_REPLY: begin
        if (rtx < min_r) begin
          min_nxt = rtx;
        end
        if (rtx > max_r) begin
          max_nxt = rtx;
        end
        recv_nxt  = recv_r + CW'(1);
        echo_nxt  = CW'(in_data.reply_echo_tx);
        peer_nxt  = rtx;
        reply_nxt = 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= slm_pkg::PH_IDLE;
      sent_r    <= '0;
      recv_r    <= '0;
      min_r     <= '1;
      max_r     <= '0;
      span_r    <= '0;
      echo_r    <= '0;
      peer_r    <= '0;
      reply_r   <= 1'b0;
      ending_r  <= 1'b0;
      invalid_r <= 1'b0;
    end else if (accept) begin
      phase_r   <= phase_nxt;
      sent_r    <= sent_nxt;
      recv_r    <= recv_nxt;
      min_r     <= min_nxt;
      max_r     <= max_nxt;
      echo_r    <= echo_nxt;
      peer_r    <= peer_nxt;
      reply_r   <= reply_nxt;
      ending_r  <= ending_nxt;
      invalid_r <= invalid_nxt;
      if (clr_span_nxt) begin
        span_r <= '0;
      end
    end else if (seq_r == slm_pkg::SEQ_SPAN && reply_r) begin
      // The peer's receive count is the span of its sequence numbers.
      span_r <= max_r - min_r + CW'(1);
    end
  end

  // Sequencer: one pass per accepted item.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seq_r <= slm_pkg::SEQ_IDLE;
    end else begin
      seq_r <= seq_nxt;
    end
  end

  always_comb begin
    seq_nxt  = seq_r;
    load_out = 1'b0;
    unique case (seq_r)
      slm_pkg::SEQ_IDLE: begin
        if (accept) begin
          seq_nxt = slm_pkg::SEQ_SPAN;
        end
      end
      slm_pkg::SEQ_SPAN: seq_nxt = slm_pkg::SEQ_LOSS;
      slm_pkg::SEQ_LOSS: seq_nxt = slm_pkg::SEQ_MUL;
      slm_pkg::SEQ_MUL:  seq_nxt = slm_pkg::SEQ_DIV;
      slm_pkg::SEQ_DIV: begin
        if (step_r == slm_pkg::STEP_W'(PB - 1)) begin
          seq_nxt = slm_pkg::SEQ_FIN;
        end
      end
      slm_pkg::SEQ_FIN: begin
        // Wait here only while the previous result has not been taken.
        if (!out_valid_r || out_ready) begin
          load_out = 1'b1;
          seq_nxt  = slm_pkg::SEQ_IDLE;
        end
      end
      default: seq_nxt = slm_pkg::SEQ_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r <= '0;
    end else if (seq_r == slm_pkg::SEQ_DIV) begin
      step_r <= step_r + slm_pkg::STEP_W'(1);
    end else begin
      step_r <= '0;
    end
  end

  // Divider lanes. The scaled loss is at most 10000 times the divisor, so its
  // top CW bits already lie below the divisor and only 14 quotient bits remain.
  always_comb begin
    for (int k = 0; k < 2; k++) begin
      prod[k]  = PW'(loss_r[k]) * PW'(slm_pkg::PCT_SCALE);
      trial[k] = {rem_r[k], dig_r[k][PB-1]};
      fits[k]  = (trial[k] >= {1'b0, den_r[k]});
      pct[k]   = dz_r[k] ? '0 : quo_r[k];
    end
    // The threshold fires below the exact percentage, so a leftover remainder
    // counts when the threshold equals the truncated value.
    hit[0] = !dz_r[0] && ((far_thr_r < pct[0]) ||
             ((far_thr_r == pct[0]) && (rem_r[0] != '0)));
    hit[1] = !dz_r[1] && ((near_thr_r < pct[1]) ||
             ((near_thr_r == pct[1]) && (rem_r[1] != '0)));
  end

  always_ff @(posedge clk) begin
    unique case (seq_r)
      slm_pkg::SEQ_LOSS: begin
        loss_r[0] <= (span_r > sent_r) ? '0 : sent_r - span_r;
        loss_r[1] <= (recv_r > span_r) ? '0 : span_r - recv_r;
        den_r[0]  <= sent_r;
        den_r[1]  <= span_r;
      end
      slm_pkg::SEQ_MUL: begin
        for (int k = 0; k < 2; k++) begin
          rem_r[k] <= prod[k][PW-1:PB];
          dig_r[k] <= prod[k][PB-1:0];
          quo_r[k] <= '0;
          dz_r[k]  <= (den_r[k] == '0);
        end
      end
      slm_pkg::SEQ_DIV: begin
        for (int k = 0; k < 2; k++) begin
          rem_r[k] <= fits[k] ? CW'(trial[k] - {1'b0, den_r[k]}) : CW'(trial[k]);
          dig_r[k] <= {dig_r[k][PB-2:0], 1'b0};
          quo_r[k] <= {quo_r[k][PB-2:0], fits[k]};
        end
      end
      default: ;
    endcase
  end

  // Far end is checked first; only the tick that ends the wait can alarm.
  always_comb begin
    if (ending_r && far_en_r && hit[0]) begin
      alarm = slm_pkg::ALARM_FAR;
    end else if (ending_r && near_en_r && hit[1]) begin
      alarm = slm_pkg::ALARM_NEAR;
    end else begin
      alarm = slm_pkg::ALARM_NONE;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (load_out) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_r.session_state   <= phase_r;
      out_r.frames_sent     <= 32'(sent_r);
      out_r.frames_received <= 32'(recv_r);
      out_r.remote_count    <= 32'(span_r);
      out_r.far_loss        <= 32'(loss_r[0]);
      out_r.near_loss       <= 32'(loss_r[1]);
      out_r.far_percent     <= pct[0];
      out_r.near_percent    <= pct[1];
      out_r.alarm_kind      <= alarm;
      out_r.result_invalid  <= invalid_r;
      out_r.last_echo_tx    <= 32'(echo_r);
      out_r.last_remote_tx  <= 32'(peer_r);
    end
  end

  // An alarm can only be reported with a session that has just finished.
  a_alarm_done: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.alarm_kind == slm_pkg::ALARM_NONE) ||
                  (out_data.session_state == slm_pkg::PH_DONE))
    else $error("alarm reported outside the done phase");

  // An invalid result always comes from a stop, which leaves the session aborted.
  a_invalid_abort: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.result_invalid |->
      out_data.session_state == slm_pkg::PH_ABORT)
    else $error("invalid flag without aborted phase");

  // A percentage never exceeds one hundred percent.
  a_pct_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.far_percent <= 14'(slm_pkg::PCT_SCALE)) &&
                  (out_data.near_percent <= 14'(slm_pkg::PCT_SCALE)))
    else $error("loss percentage out of range");

  // An accepted transfer starts the sequencer in the next cycle.
  a_seq_start: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> seq_r == slm_pkg::SEQ_SPAN)
    else $error("sequencer did not start after a transfer");

  // The loaded result is held until the transfer completes.
  a_out_wait: assert property (@(posedge clk) disable iff (!rst_n)
    seq_r == slm_pkg::SEQ_FIN && out_valid && !out_ready |=> seq_r == slm_pkg::SEQ_FIN)
    else $error("result overwritten before transfer");

endmodule

`default_nettype wire

[tb/sv/slm_checker.sv]
// Checker for the synthetic loss measurement session: watches both channels
// and the register port, predicts each status transfer and compares it.
// Depends on slm_pkg for the transfer structs, enums and register indexes.
module slm_checker
  import slm_pkg::*;
(
  input  wire        clk,
  input  wire        rst_n,
  input  wire        in_valid,
  input  wire        in_ready,
  input  in_item_t   in_data,
  input  wire        out_valid,
  input  wire        out_ready,
  input  out_item_t  out_data,
  input  wire        cfg_we,
  input  wire [CFG_IDX_W-1:0]  cfg_index,
  input  wire [CFG_DATA_W-1:0] cfg_wdata,
  output int         mismatches,
  output int         outstanding
);
  timeunit 1ns;
  timeprecision 1ps;

  // Register shadow.
  logic [15:0] pkt_target;
  logic        far_en;
  logic [13:0] far_limit;
  logic        near_en;
  logic [13:0] near_limit;

  // Session state shadow.
  phase_t      phase;
  logic [31:0] sent_cnt;
  logic [31:0] rcvd_cnt;
  logic [31:0] min_seq;
  logic [31:0] max_seq;
  logic [31:0] span;
  logic [31:0] echo_seq;
  logic [31:0] peer_seq;

  out_item_t   status_q[$];
  out_item_t   want;
  out_item_t   status;
  int          error_total = 0;

  // Loss in hundredths of a percent, truncated; bit 14 flags a remainder.
  function automatic logic [14:0] scaled_loss(input logic [31:0] loss,
                                              input logic [31:0] base);
    logic [63:0] num;
    logic [63:0] den;
    logic [63:0] quo;
    if (base == 32'd0) return '0;
    num = {32'd0, loss} * 64'd10000;
    den = {32'd0, base};
    quo = num / den;
    return {(num % den) != 64'd0, quo[13:0]};
  endfunction

  // The limit trips when it lies below the exact, untruncated percentage.
  function automatic bit over_limit(input logic [13:0] limit, input logic [14:0] pct);
    return (limit < pct[13:0]) || (limit == pct[13:0] && pct[14]);
  endfunction

  task automatic advance_session(input in_item_t ev, output out_item_t st);
    logic [31:0] far_l;
    logic [31:0] near_l;
    logic [14:0] far_s;
    logic [14:0] near_s;
    bit          ending;
    bit          invalid;
    alarm_t      alarm;
    ending = 1'b0;
    invalid = 1'b0;
    alarm = ALARM_NONE;
    case (action_t'(ev.action))
      ACT_START: begin
        phase = PH_RUN;
        sent_cnt = '0;
        rcvd_cnt = '0;
        min_seq = '1;
        max_seq = '0;
        span = '0;
        echo_seq = '0;
        peer_seq = '0;
      end
      ACT_STOP: begin
        invalid = (phase != PH_DONE);
        phase = PH_ABORT;
      end
      ACT_TICK: begin
        if (phase == PH_RUN) begin
          if (ev.send_ok) sent_cnt = sent_cnt + 32'd1;
          if (sent_cnt == {16'd0, pkt_target}) phase = PH_WAIT;
        end else if (phase == PH_WAIT) begin
          phase = PH_DONE;
          ending = 1'b1;
        end
      end
      default: begin
        if (ev.reply_remote_tx < min_seq) min_seq = ev.reply_remote_tx;
        if (ev.reply_remote_tx > max_seq) max_seq = ev.reply_remote_tx;
        rcvd_cnt = rcvd_cnt + 32'd1;
        span = max_seq - min_seq + 32'd1;
        echo_seq = ev.reply_echo_tx;
        peer_seq = ev.reply_remote_tx;
      end
    endcase

    far_l = (span > sent_cnt) ? 32'd0 : sent_cnt - span;
    near_l = (rcvd_cnt > span) ? 32'd0 : span - rcvd_cnt;
    far_s = scaled_loss(far_l, sent_cnt);
    near_s = scaled_loss(near_l, span);

    if (ending) begin
      if (far_en && over_limit(far_limit, far_s)) alarm = ALARM_FAR;
      else if (near_en && over_limit(near_limit, near_s)) alarm = ALARM_NEAR;
    end

    st.session_state = phase;
    st.frames_sent = sent_cnt;
    st.frames_received = rcvd_cnt;
    st.remote_count = span;
    st.far_loss = far_l;
    st.near_loss = near_l;
    st.far_percent = far_s[13:0];
    st.near_percent = near_s[13:0];
    st.alarm_kind = alarm;
    st.result_invalid = invalid;
    st.last_echo_tx = echo_seq;
    st.last_remote_tx = peer_seq;
  endtask

  task automatic check_field(input string name, input logic [31:0] exp_val,
                             input logic [31:0] got_val);
    if (got_val !== exp_val) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, exp_val, got_val);
      error_total++;
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      pkt_target = PACKET_COUNT_RESET;
      far_en = 1'b0;
      far_limit = '0;
      near_en = 1'b0;
      near_limit = '0;
      phase = PH_IDLE;
      sent_cnt = '0;
      rcvd_cnt = '0;
      min_seq = '1;
      max_seq = '0;
      span = '0;
      echo_seq = '0;
      peer_seq = '0;
      status_q.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_PACKET_COUNT: pkt_target = cfg_wdata;
          CFG_FAR_THR_EN:   far_en = cfg_wdata[0];
          CFG_FAR_THR:      far_limit = cfg_wdata[13:0];
          CFG_NEAR_THR_EN:  near_en = cfg_wdata[0];
          CFG_NEAR_THR:     near_limit = cfg_wdata[13:0];
          default: ;
        endcase
      end

      if (out_valid && out_ready) begin
        if (status_q.size() == 0) begin
          $error("status transfer with no event outstanding");
          error_total++;
        end else begin
          want = status_q.pop_front();
          check_field("session_state", want.session_state, out_data.session_state);
          check_field("frames_sent", want.frames_sent, out_data.frames_sent);
          check_field("frames_received", want.frames_received, out_data.frames_received);
          check_field("remote_count", want.remote_count, out_data.remote_count);
          check_field("far_loss", want.far_loss, out_data.far_loss);
          check_field("near_loss", want.near_loss, out_data.near_loss);
          check_field("far_percent", want.far_percent, out_data.far_percent);
          check_field("near_percent", want.near_percent, out_data.near_percent);
          check_field("alarm_kind", want.alarm_kind, out_data.alarm_kind);
          check_field("result_invalid", want.result_invalid, out_data.result_invalid);
          check_field("last_echo_tx", want.last_echo_tx, out_data.last_echo_tx);
          check_field("last_remote_tx", want.last_remote_tx, out_data.last_remote_tx);
        end
      end

      if (in_valid && in_ready) begin
        advance_session(in_data, status);
        status_q.push_back(status);
      end
    end
    mismatches <= error_total;
    outstanding <= status_q.size();
  end

endmodule

[tb/sv/testbench.sv]
// Top of the synthetic loss measurement session testbench: clock, reset,
// event stimulus, register programming and the final verdict.
// Depends on slm_pkg, the session RTL and slm_checker.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import slm_pkg::*;

  // Settling time after a drain, with margin over the time one event needs.
  localparam int SETTLE_CYCLES = 30;
  // About 2000 events fit well inside this bound.
  localparam int CYCLE_LIMIT = 1_000_000;
  localparam int NUM_PHASES = 9;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic      in_valid = 1'b0;
  logic      in_ready;
  in_item_t  in_data = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_item_t out_data;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  int fail_count;
  int outstanding;
  int cycle_count = 0;
  int events_sent = 0;
  // While set, neither side inserts idle cycles.
  bit quiet_mode = 1'b0;

  always #2 clk = ~clk;

  synthetic_loss_measurement_session dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  slm_checker u_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_data     (in_data),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_data    (out_data),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_wdata   (cfg_wdata),
    .mismatches  (fail_count),
    .outstanding (outstanding)
  );

  // The receiver withholds out_ready with a 31 percent chance, except while the
  // quiet stretch is running.
  always @(negedge clk) begin
    out_ready <= quiet_mode || ($urandom_range(0, 99) >= 31);
  end

  // Watchdog: a hung handshake ends the run as a failure.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $error("no progress after %0d cycles", CYCLE_LIMIT);
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  function automatic in_item_t make_event(input action_t act, input bit ok,
                                          input logic [31:0] rtx,
                                          input logic [31:0] etx);
    in_item_t ev;
    ev.action = act;
    ev.send_ok = ok;
    ev.reply_remote_tx = rtx;
    ev.reply_echo_tx = etx;
    return ev;
  endfunction

  // Offers one event and returns at the rising edge where it is transferred.
  // Valid stays high afterwards, so back-to-back events never drop it; the
  // next call either idles (valid low) or presents new data at a falling edge.
  task automatic push_event(input in_item_t ev);
    @(negedge clk);
    while (!quiet_mode && $urandom_range(0, 99) < 31) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data <= ev;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    events_sent++;
  endtask

  // Holds the sender off until every predicted status has been transferred,
  // then lets the datapath settle. Ends on a falling edge.
  task automatic drain;
    @(negedge clk);
    in_valid <= 1'b0;
    while (outstanding != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // Must be entered on a falling edge; each write lands on the next rising edge.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(negedge clk);
  endtask

  task automatic apply_settings(input logic [15:0] pkts, input bit fe,
                                input logic [13:0] ft, input bit ne,
                                input logic [13:0] nt);
    write_reg(CFG_PACKET_COUNT, pkts);
    write_reg(CFG_FAR_THR_EN, {15'd0, fe});
    write_reg(CFG_FAR_THR, {2'd0, ft});
    write_reg(CFG_NEAR_THR_EN, {15'd0, ne});
    write_reg(CFG_NEAR_THR, {2'd0, nt});
    cfg_we <= 1'b0;
  endtask

  // Threshold values mix the extremes, the widest encodable value, and round
  // figures that land exactly on typical small-count loss percentages.
  function automatic logic [13:0] pick_limit();
    case ($urandom_range(0, 7))
      0: return 14'd0;
      1: return 14'd10000;
      2: return 14'h3FFF;
      3: return 14'd3333;
      4: return 14'd5000;
      5: return 14'($urandom_range(0, 20) * 500);
      6: return 14'($urandom_range(0, 2000));
      default: return 14'($urandom_range(0, 10000));
    endcase
  endfunction

  task automatic send_noise;
    push_event(make_event(action_t'($urandom_range(0, 3)), $urandom_range(0, 1),
                          $urandom, $urandom));
  endtask

  // One measurement session: start, ticks with mostly successful sends,
  // replies with a running peer sequence (some lost, some repeated), then the
  // closing tick. Short sessions are cut off by a stop instead; that is also
  // the only way out when the frame target is zero or very large.
  task automatic run_session(input int unsigned pkts);
    int unsigned ok_sends;
    int unsigned ticks;
    int unsigned tick_cap;
    logic [31:0] base;
    logic [31:0] seq;
    bit          cut_short;
    bit          ok;
    cut_short = (pkts == 0) || (pkts > 40) || ($urandom_range(0, 9) == 0);
    tick_cap = $urandom_range(1, 30);
    // Some sessions start just below the top of the sequence space so that
    // the peer sequence wraps and the span gets huge.
    base = ($urandom_range(0, 3) == 0) ? 32'hFFFF_FFF8 + $urandom_range(0, 7) : $urandom;
    seq = '0;
    ok_sends = 0;
    ticks = 0;
    push_event(make_event(ACT_START, $urandom_range(0, 1), $urandom, $urandom));
    while (cut_short ? (ticks < tick_cap) : (ok_sends < pkts)) begin
      ok = ($urandom_range(0, 9) != 0);
      push_event(make_event(ACT_TICK, ok, $urandom, $urandom));
      ticks++;
      if (ok) ok_sends++;
      if (ok && $urandom_range(0, 99) < 85) begin
        if ($urandom_range(0, 9) == 0)
          push_event(make_event(ACT_REPLY, $urandom_range(0, 1), base + seq - 32'd1, $urandom));
        else
          push_event(make_event(ACT_REPLY, $urandom_range(0, 1), base + seq, $urandom));
      end
      seq = seq + (($urandom_range(0, 7) == 0) ? 32'd2 : 32'd1);
      if ($urandom_range(0, 99) < 4) send_noise();
    end
    if (cut_short) begin
      push_event(make_event(ACT_STOP, $urandom_range(0, 1), $urandom, $urandom));
    end else begin
      push_event(make_event(ACT_TICK, $urandom_range(0, 1), $urandom, $urandom));
      if ($urandom_range(0, 99) < 30)
        push_event(make_event(ACT_REPLY, 1'b0, base + seq, $urandom));
      if ($urandom_range(0, 99) < 40)
        push_event(make_event(ACT_STOP, 1'b0, $urandom, $urandom));
    end
  endtask

  initial begin
    logic [15:0] pkts;
    bit          fe;
    bit          ne;
    logic [13:0] ft;
    logic [13:0] nt;
    int          budget;
    int          phase_end;

    // Synchronous reset, released at a falling edge.
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed opening: two-frame sessions with the far check at zero and
    // the near check at its ceiling.
    apply_settings(16'd2, 1'b1, 14'd0, 1'b1, 14'd10000);
    push_event(make_event(ACT_TICK, 1'b1, '0, '0));                 // tick while idle
    push_event(make_event(ACT_STOP, 1'b0, '0, '0));                 // stop while idle
    push_event(make_event(ACT_TICK, 1'b1, '1, '1));                 // tick while aborted
    push_event(make_event(ACT_REPLY, 1'b0, 32'hFFFF_FFFF, 32'd0));  // reply outside a session
    push_event(make_event(ACT_REPLY, 1'b1, 32'd0, 32'hFFFF_FFFF));  // span wraps to zero
    push_event(make_event(ACT_START, 1'b0, '1, '1));
    push_event(make_event(ACT_TICK, 1'b0, '0, '0));                 // failed send
    push_event(make_event(ACT_TICK, 1'b1, '0, '0));
    push_event(make_event(ACT_REPLY, 1'b0, 32'd5, 32'd1));
    push_event(make_event(ACT_REPLY, 1'b0, 32'd5, 32'd2));          // received above span
    push_event(make_event(ACT_TICK, 1'b1, '0, '0));                 // target reached
    push_event(make_event(ACT_TICK, 1'b0, '0, '0));                 // ends wait, far alarm
    push_event(make_event(ACT_TICK, 1'b1, '0, '0));                 // tick while done
    push_event(make_event(ACT_STOP, 1'b0, '0, '0));                 // clean stop after done
    push_event(make_event(ACT_START, 1'b1, '0, '0));
    push_event(make_event(ACT_START, 1'b0, '0, '0));                // restart while running
    push_event(make_event(ACT_STOP, 1'b1, '0, '0));                 // stop while running
    drain();

    // Random phases, each with its own register settings.
    for (int p = 1; p <= NUM_PHASES; p++) begin
      budget = 215;
      pkts = 16'($urandom_range(1, 12));
      fe = $urandom_range(0, 1);
      ne = $urandom_range(0, 1);
      ft = pick_limit();
      nt = pick_limit();
      case (p)
        1: begin
          // Single-frame sessions with the near check at zero.
          pkts = 16'd1;
          fe = 1'b0;
          ft = 14'd0;
          ne = 1'b1;
          nt = 14'd0;
        end
        2: begin
          // A zero target only ends on a failed first send or a stop.
          pkts = 16'd0;
          fe = 1'b1;
          ne = 1'b1;
        end
        3: begin
          // Largest target and widest thresholds; sessions are all cut short.
          pkts = 16'hFFFF;
          fe = 1'b1;
          ft = 14'h3FFF;
          ne = 1'b1;
          nt = 14'h3FFF;
          budget = 80;
        end
        4: begin
          fe = 1'b1;
          ne = 1'b1;
          quiet_mode = 1'b1;
        end
        5: quiet_mode = 1'b0;
        default: ;
      endcase
      apply_settings(pkts, fe, ft, ne, nt);
      phase_end = events_sent + budget;
      while (events_sent < phase_end) begin
        if ($urandom_range(0, 99) < 10) send_noise();
        else run_session(pkts);
      end
      // The sender waits for every status before the next reprogramming.
      drain();
    end

    if (fail_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
